### src/fhtlv_pkg.sv
`default_nettype none
package fhtlv_pkg;

  localparam int unsigned MAX_HEADER_BYTES_DEF = 1024;

  localparam logic [7:0] MARK_HI = 8'hAA;
  localparam logic [7:0] MARK_LO = 8'h55;
  localparam logic [15:0] END_ID = 16'h0000;

  // Parser phases
  localparam logic [2:0] PH_MARK0 = 3'd0;
  localparam logic [2:0] PH_MARK1 = 3'd1;
  localparam logic [2:0] PH_IDLO  = 3'd2;
  localparam logic [2:0] PH_IDHI  = 3'd3;
  localparam logic [2:0] PH_LEN   = 3'd4;
  localparam logic [2:0] PH_VAL   = 3'd5;
  localparam logic [2:0] PH_END   = 3'd6;

  // Byte roles
  localparam logic [2:0] ROLE_MARK = 3'd0;
  localparam logic [2:0] ROLE_IDLO = 3'd1;
  localparam logic [2:0] ROLE_IDHI = 3'd2;
  localparam logic [2:0] ROLE_LEN  = 3'd3;
  localparam logic [2:0] ROLE_VAL  = 3'd4;
  localparam logic [2:0] ROLE_TERM = 3'd5;
  localparam logic [2:0] ROLE_IGN  = 3'd6;

  // Parse status
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] cur_id;
    logic [7:0]  cur_len;
    logic [7:0]  val_pos;
    logic [1:0]  status;
    logic        term_seen;
  } fhtlv_state_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [15:0] item_id;
    logic [7:0]  item_length;
    logic [7:0]  value_index;
    logic [7:0]  value_byte;
    logic        item_done;
    logic [1:0]  parse_status;
  } fhtlv_result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } fhtlv_input_t;

endpackage
`default_nettype wire

### src/fhtlv_step.sv
`default_nettype none
module fhtlv_step
  import fhtlv_pkg::*;
#(
  parameter int unsigned MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF,
  parameter int unsigned SIZE_W = $clog2(MAX_HEADER_BYTES + 1)
) (
  input  fhtlv_state_t  st_cur,
  input  logic [SIZE_W-1:0] size_cur,
  input  fhtlv_input_t  item,
  output fhtlv_state_t  st_nxt,
  output logic [SIZE_W-1:0] size_nxt,
  output fhtlv_result_t res
);

  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_HEADER_BYTES);

  fhtlv_state_t      st;
  logic [SIZE_W-1:0] size;
  fhtlv_state_t      ns;
  logic [SIZE_W-1:0] nsize;
  logic [2:0]        role;
  logic [7:0]        vindex;
  logic              done;
  logic [15:0]       full_id;
  logic [7:0]        pos_inc;

  always_comb begin
    // A restart clears everything before the byte is taken as a mark byte.
    if (item.first_byte) begin
      st = '0;
      st.phase = PH_MARK0;
      size = '0;
    end else begin
      st = st_cur;
      size = size_cur;
    end

    ns = st;
    nsize = size;
    role = ROLE_IGN;
    vindex = 8'd0;
    done = 1'b0;
    full_id = {item.data_byte, st.cur_id[7:0]};
    pos_inc = st.val_pos + 8'd1;

    if (st.phase < PH_END) begin
      if (size < SIZE_MAX) begin
        nsize = size + SIZE_W'(1);
      end
      unique case (st.phase)
        PH_MARK0: begin
          role = ROLE_MARK;
          if (item.data_byte != MARK_HI) begin
            ns.status = ST_BAD;
            ns.phase = PH_END;
          end else begin
            ns.phase = PH_MARK1;
          end
        end
        PH_MARK1: begin
          role = ROLE_MARK;
          if (item.data_byte != MARK_LO) begin
            ns.status = ST_BAD;
            ns.phase = PH_END;
          end else begin
            ns.phase = PH_IDLO;
          end
        end
        PH_IDLO: begin
          role = ROLE_IDLO;
          ns.cur_id = {8'd0, item.data_byte};
          ns.cur_len = 8'd0;
          ns.val_pos = 8'd0;
          ns.term_seen = 1'b0;
          ns.phase = PH_IDHI;
        end
        PH_IDHI: begin
          ns.cur_id = full_id;
          ns.term_seen = (full_id == END_ID);
          role = (full_id == END_ID) ? ROLE_TERM : ROLE_IDHI;
          ns.phase = PH_LEN;
        end
        PH_LEN: begin
          role = st.term_seen ? ROLE_TERM : ROLE_LEN;
          ns.cur_len = item.data_byte;
          ns.val_pos = 8'd0;
          if (item.data_byte == 8'd0) begin
            done = 1'b1;
          end else begin
            ns.phase = PH_VAL;
          end
        end
        PH_VAL: begin
          role = st.term_seen ? ROLE_TERM : ROLE_VAL;
          vindex = st.val_pos;
          ns.val_pos = pos_inc;
          if (pos_inc == st.cur_len) begin
            done = 1'b1;
          end
        end
        default: begin
          ns.phase = PH_END;
        end
      endcase
      // The terminator completes the header; any other item leads to the next id.
      if (done) begin
        if (st.term_seen) begin
          ns.status = ST_DONE;
          ns.phase = PH_END;
        end else begin
          ns.phase = PH_IDLO;
        end
      end
      if (item.last_byte && ns.status == ST_RUN) begin
        ns.status = ST_TRUNC;
        ns.phase = PH_END;
      end
    end else begin
      ns.phase = PH_END;
    end

    st_nxt = ns;
    size_nxt = nsize;
    res.byte_role = role;
    res.item_id = ns.cur_id;
    res.item_length = ns.cur_len;
    res.value_index = vindex;
    res.value_byte = item.data_byte;
    res.item_done = done;
    res.parse_status = ns.status;
  end

endmodule
`default_nettype wire

### src/file_header_tlv_parser.sv
`default_nettype none
// Byte-serial parser for a type-length-value header opening with the mark AA 55.
// Each accepted byte gives exactly one result transaction, reporting its role,
// the current item id and length, the value index, the status and the running
// consumed size. It takes one byte every cycle while the output is not stalled.
// Each result is presented from the result register: the byte is first held in
// the input register, and the whole parser state is updated as the result
// register loads. A stalled result register also stalls a full input register.
module file_header_tlv_parser
  import fhtlv_pkg::*;
#(
  parameter int unsigned MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF,
  parameter int unsigned SIZE_W = $clog2(MAX_HEADER_BYTES + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_first_byte,
  input  wire logic              in_last_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_byte_role,
  output logic [15:0]            out_item_id,
  output logic [7:0]             out_item_length,
  output logic [7:0]             out_value_index,
  output logic [7:0]             out_value_byte,
  output logic                   out_item_done,
  output logic [1:0]             out_parse_status,
  output logic [SIZE_W-1:0]      out_header_size
);

  logic              in_valid_r;
  fhtlv_input_t      in_item_r;
  fhtlv_state_t      st_r;
  fhtlv_state_t      st_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] size_nxt;
  fhtlv_result_t     res_nxt;
  fhtlv_result_t     res_r;
  logic [SIZE_W-1:0] res_size_r;
  logic              out_valid_r;
  logic              advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  fhtlv_step #(
    .MAX_HEADER_BYTES(MAX_HEADER_BYTES),
    .SIZE_W(SIZE_W)
  ) u_step (
    .st_cur(st_r),
    .size_cur(size_r),
    .item(in_item_r),
    .st_nxt(st_nxt),
    .size_nxt(size_nxt),
    .res(res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      st_r <= '0;
      size_r <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        st_r <= st_nxt;
        size_r <= size_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r.data_byte <= in_data_byte;
      in_item_r.first_byte <= in_first_byte;
      in_item_r.last_byte <= in_last_byte;
    end
    if (advance) begin
      res_r <= res_nxt;
      res_size_r <= size_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_role    = res_r.byte_role;
  assign out_item_id      = res_r.item_id;
  assign out_item_length  = res_r.item_length;
  assign out_value_index  = res_r.value_index;
  assign out_value_byte   = res_r.value_byte;
  assign out_item_done    = res_r.item_done;
  assign out_parse_status = res_r.parse_status;
  assign out_header_size  = res_size_r;

  // The parse only stops with a final status recorded.
  a_end_has_status: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_END) |-> (st_r.status != ST_RUN))
    else $error("parser stopped without a final status");

  a_size_limit: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= SIZE_W'(MAX_HEADER_BYTES))
    else $error("consumed size beyond its limit");

  // Ignored bytes leave the consumed size untouched.
  a_ignored_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_nxt.byte_role == ROLE_IGN) |=> $stable(size_r))
    else $error("ignored byte changed the consumed size");

  a_done_role: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.item_done) |->
      (res_r.byte_role == ROLE_LEN || res_r.byte_role == ROLE_VAL ||
       res_r.byte_role == ROLE_TERM))
    else $error("item completed on a byte that is not length or value");

endmodule
`default_nettype wire
